/* design/ssoc_pkg.sv */
// shared types and default sizes for the sweep segment order comparator
package ssoc_pkg;

  // default field widths
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned IDENT_WIDTH_DEF = 16;

  // sign of one orientation area
  typedef struct packed {
    logic lt;  // area below zero
    logic gt;  // area above zero
  } orient_t;

  // per-stage load enables of the orientation pipeline
  typedef struct packed {
    logic diff;  // stage 1: coordinate differences
    logic prod;  // stage 2: cross products
    logic sign;  // stage 3: area sign
  } stage_en_t;

endpackage

/* design/ssoc_orient.sv */
// three-stage orientation test: sign of area(a, b, c) over registered stages
module ssoc_orient import ssoc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  stage_en_t                     en_i,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  input  logic signed [COORD_WIDTH-1:0] c_x_i,
  input  logic signed [COORD_WIDTH-1:0] c_y_i,
  output orient_t                       sign_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] cxa_d, bya_d, bxa_d, cya_d;
  logic signed [DW-1:0] cxa_q, bya_q, bxa_q, cya_q;
  logic signed [PW-1:0] prod_l_d, prod_r_d;
  logic signed [PW-1:0] prod_l_q, prod_r_q;
  orient_t              sign_d, sign_q;

  // stage 1: differences against point a, one bit wider
  always_comb begin
    cxa_d = $signed({c_x_i[COORD_WIDTH-1], c_x_i}) - $signed({a_x_i[COORD_WIDTH-1], a_x_i});
    bya_d = $signed({b_y_i[COORD_WIDTH-1], b_y_i}) - $signed({a_y_i[COORD_WIDTH-1], a_y_i});
    bxa_d = $signed({b_x_i[COORD_WIDTH-1], b_x_i}) - $signed({a_x_i[COORD_WIDTH-1], a_x_i});
    cya_d = $signed({c_y_i[COORD_WIDTH-1], c_y_i}) - $signed({a_y_i[COORD_WIDTH-1], a_y_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.diff) begin
      cxa_q <= cxa_d;
      bya_q <= bya_d;
      bxa_q <= bxa_d;
      cya_q <= cya_d;
    end
  end

  // stage 2: the two cross-product terms at full width
  always_comb begin
    prod_l_d = PW'(cxa_q) * PW'(bya_q);
    prod_r_d = PW'(bxa_q) * PW'(cya_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
  end

  // stage 3: compare terms to get the area sign
  always_comb begin
    sign_d.lt = prod_l_q < prod_r_q;
    sign_d.gt = prod_l_q > prod_r_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sign) begin
      sign_q <= sign_d;
    end
  end

  assign sign_o = sign_q;

endmodule

/* design/sweep_segment_order_compare_top.sv */
// top level of the sweep segment order comparator
//
// Decides whether segment 1 orders before segment 2 on a sweep-line status
// structure. Each segment is a start point, an end point and an identity.
// Items arrive on the s_axis stream; one single-bit answer per item leaves on
// the m_axis stream, in order. There are no registers to program and no state
// kept between items.
//
// Coordinate differences, cross products, area sign compare and the final
// select each sit in their own register stage, in that order, with the four
// orientation tests running side by side. A new item is taken every cycle
// while m_axis_tready stays high.
//
// Every stage holds its item while the next one is full and stalled, so when
// m_axis_tready drops the pipeline fills and s_axis_tready falls once all four
// stages are occupied; nothing is lost or repeated. Reset clears all valid
// bits, leaving the pipeline empty and ready.
module sweep_segment_order_compare_top import ssoc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned IDENT_WIDTH = IDENT_WIDTH_DEF,
  localparam int unsigned IN_BITS    = 8 * COORD_WIDTH + 2 * IDENT_WIDTH,
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // lowest bit up: seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y, seg1_ident,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, seg2_ident, zero pad
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // lowest bit up: first_before, zero pad
  output logic [7:0]            m_axis_tdata
);

  // field offsets inside s_axis_tdata
  localparam int unsigned OFF_S1X = 0;
  localparam int unsigned OFF_S1Y = OFF_S1X + COORD_WIDTH;
  localparam int unsigned OFF_E1X = OFF_S1Y + COORD_WIDTH;
  localparam int unsigned OFF_E1Y = OFF_E1X + COORD_WIDTH;
  localparam int unsigned OFF_ID1 = OFF_E1Y + COORD_WIDTH;
  localparam int unsigned OFF_S2X = OFF_ID1 + IDENT_WIDTH;
  localparam int unsigned OFF_S2Y = OFF_S2X + COORD_WIDTH;
  localparam int unsigned OFF_E2X = OFF_S2Y + COORD_WIDTH;
  localparam int unsigned OFF_E2Y = OFF_E2X + COORD_WIDTH;
  localparam int unsigned OFF_ID2 = OFF_E2Y + COORD_WIDTH;

  // case flags that travel with each item
  typedef struct packed {
    logic id_eq;       // identities match
    logic id_lt;       // seg1 identity smaller
    logic same_start;  // identical start points
    logic s1_earlier;  // seg1 starts left, or lower at the same x
  } case_flags_t;

  logic signed [COORD_WIDTH-1:0] s1_x, s1_y, e1_x, e1_y;
  logic signed [COORD_WIDTH-1:0] s2_x, s2_y, e2_x, e2_y;
  logic        [IDENT_WIDTH-1:0] id1, id2;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        rdy1, rdy2, rdy3, rdy4;
  case_flags_t flags1_d, flags1_q, flags2_q, flags3_q;
  stage_en_t   stage_en;
  orient_t     a1_sign, a2_sign, b1_sign, b2_sign;
  logic        res_d, res_q;

  // unpack the input transfer
  always_comb begin
    s1_x = $signed(s_axis_tdata[OFF_S1X +: COORD_WIDTH]);
    s1_y = $signed(s_axis_tdata[OFF_S1Y +: COORD_WIDTH]);
    e1_x = $signed(s_axis_tdata[OFF_E1X +: COORD_WIDTH]);
    e1_y = $signed(s_axis_tdata[OFF_E1Y +: COORD_WIDTH]);
    id1  = s_axis_tdata[OFF_ID1 +: IDENT_WIDTH];
    s2_x = $signed(s_axis_tdata[OFF_S2X +: COORD_WIDTH]);
    s2_y = $signed(s_axis_tdata[OFF_S2Y +: COORD_WIDTH]);
    e2_x = $signed(s_axis_tdata[OFF_E2X +: COORD_WIDTH]);
    e2_y = $signed(s_axis_tdata[OFF_E2Y +: COORD_WIDTH]);
    id2  = s_axis_tdata[OFF_ID2 +: IDENT_WIDTH];
  end

  // stage ready chain: a stage loads when empty or when its item moves on
  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;

  assign stage_en.diff = rdy1;
  assign stage_en.prod = rdy2;
  assign stage_en.sign = rdy3;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1 case flags from start points and identities
  always_comb begin
    flags1_d.id_eq      = id1 == id2;
    flags1_d.id_lt      = id1 < id2;
    flags1_d.same_start = (s1_x == s2_x) && (s1_y == s2_y);
    flags1_d.s1_earlier = (s1_x < s2_x) || ((s1_x == s2_x) && (s1_y < s2_y));
  end

  // flags follow the item through the arithmetic stages
  always_ff @(posedge clk_i) begin
    if (rdy1) flags1_q <= flags1_d;
    if (rdy2) flags2_q <= flags1_q;
    if (rdy3) flags3_q <= flags2_q;
  end

  // area(s1, e1, s2)
  ssoc_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_a1 (
    .clk_i (clk_i), .en_i (stage_en),
    .a_x_i (s1_x), .a_y_i (s1_y), .b_x_i (e1_x), .b_y_i (e1_y),
    .c_x_i (s2_x), .c_y_i (s2_y), .sign_o (a1_sign)
  );

  // area(s1, e1, e2)
  ssoc_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_a2 (
    .clk_i (clk_i), .en_i (stage_en),
    .a_x_i (s1_x), .a_y_i (s1_y), .b_x_i (e1_x), .b_y_i (e1_y),
    .c_x_i (e2_x), .c_y_i (e2_y), .sign_o (a2_sign)
  );

  // area(s2, e2, s1)
  ssoc_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_b1 (
    .clk_i (clk_i), .en_i (stage_en),
    .a_x_i (s2_x), .a_y_i (s2_y), .b_x_i (e2_x), .b_y_i (e2_y),
    .c_x_i (s1_x), .c_y_i (s1_y), .sign_o (b1_sign)
  );

  // area(s2, e2, e1)
  ssoc_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_b2 (
    .clk_i (clk_i), .en_i (stage_en),
    .a_x_i (s2_x), .a_y_i (s2_y), .b_x_i (e2_x), .b_y_i (e2_y),
    .c_x_i (e1_x), .c_y_i (e1_y), .sign_o (b2_sign)
  );

  // stage 4: pick the answer for the case at hand
  always_comb begin
    priority if (flags3_q.id_eq) begin
      res_d = 1'b0;
    end else if (flags3_q.same_start) begin
      priority if (a2_sign.lt) res_d = 1'b1;
      else if (a2_sign.gt)     res_d = 1'b0;
      else                     res_d = flags3_q.id_lt;
    end else if (flags3_q.s1_earlier) begin
      priority if (a1_sign.lt) res_d = 1'b1;
      else if (a1_sign.gt)     res_d = 1'b0;
      else                     res_d = !a2_sign.gt;
    end else begin
      priority if (b1_sign.gt) res_d = 1'b1;
      else if (b1_sign.lt)     res_d = 1'b0;
      else                     res_d = b2_sign.gt;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (rdy4) res_q <= res_d;
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {7'b0, res_q};

  // input stalls only with every stage occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with an empty pipeline stage");

  // an item leaving stage 3 shows up at the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> m_axis_tvalid)
    else $error("item lost between stage 3 and output");

  // matching identities always give a zero answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4 && flags3_q.id_eq) |=> !m_axis_tdata[0])
    else $error("equal identities ordered first");

  // an accepted input item always lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted item missing in stage 1");

endmodule

/* tb/sv/ssoc_order_checker.sv */
// checker that predicts and compares the segment order answers of the comparator
`timescale 1ns / 100ps

module ssoc_order_checker import ssoc_pkg::*; #(
  parameter int unsigned CW   = COORD_WIDTH_DEF,
  parameter int unsigned IW   = IDENT_WIDTH_DEF,
  parameter int unsigned IN_W = ((8 * CW + 2 * IW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input stream as seen by the block
  input  logic            s_tvalid_i,
  input  logic            s_tready_i,
  input  logic [IN_W-1:0] s_tdata_i,
  // result stream as seen by the block
  input  logic            m_tvalid_i,
  input  logic            m_tready_i,
  input  logic [7:0]      m_tdata_i,
  output int              mismatches_o,
  output int              pending_o,
  output int              results_o,
  output int              tie_breaks_o
);

  // input transfer layout, lowest field last
  typedef struct packed {
    logic        [IW-1:0] seg2_ident;
    logic signed [CW-1:0] seg2_end_y;
    logic signed [CW-1:0] seg2_end_x;
    logic signed [CW-1:0] seg2_start_y;
    logic signed [CW-1:0] seg2_start_x;
    logic        [IW-1:0] seg1_ident;
    logic signed [CW-1:0] seg1_end_y;
    logic signed [CW-1:0] seg1_end_x;
    logic signed [CW-1:0] seg1_start_y;
    logic signed [CW-1:0] seg1_start_x;
  } seg_pair_t;

  bit expected_before_q[$];
  int mismatch_cnt = 0;
  int pending_cnt  = 0;
  int result_cnt   = 0;
  int tie_cnt      = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;
  assign results_o    = result_cnt;
  assign tie_breaks_o = tie_cnt;

  // sign of (c-a) x (b-a), wide enough that no product overflows
  function automatic int area_sign(input longint ax, ay, bx, by, cx, cy);
    longint lhs;
    longint rhs;
    lhs = (cx - ax) * (by - ay);
    rhs = (bx - ax) * (cy - ay);
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  // status-line order of segment 1 against segment 2
  function automatic bit predict_first_before(input seg_pair_t p, output bit tie_broken);
    longint s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
    int     o;
    s1x = $signed(p.seg1_start_x);
    s1y = $signed(p.seg1_start_y);
    e1x = $signed(p.seg1_end_x);
    e1y = $signed(p.seg1_end_y);
    s2x = $signed(p.seg2_start_x);
    s2y = $signed(p.seg2_start_y);
    e2x = $signed(p.seg2_end_x);
    e2y = $signed(p.seg2_end_y);
    tie_broken = 1'b0;
    if (p.seg1_ident == p.seg2_ident) return 1'b0;
    // shared start: orientation of the far end, then the identity
    if (s1x == s2x && s1y == s2y) begin
      o = area_sign(s1x, s1y, e1x, e1y, e2x, e2y);
      if (o != 0) return o < 0;
      tie_broken = 1'b1;
      return p.seg1_ident < p.seg2_ident;
    end
    // segment 1 starts first: place segment 2 against it
    if (s1x < s2x || (s1x == s2x && s1y < s2y)) begin
      o = area_sign(s1x, s1y, e1x, e1y, s2x, s2y);
      if (o != 0) return o < 0;
      tie_broken = 1'b1;
      return area_sign(s1x, s1y, e1x, e1y, e2x, e2y) <= 0;
    end
    // segment 2 starts first: place segment 1 against it
    o = area_sign(s2x, s2y, e2x, e2y, s1x, s1y);
    if (o != 0) return o > 0;
    tie_broken = 1'b1;
    return area_sign(s2x, s2y, e2x, e2y, e1x, e1y) > 0;
  endfunction

  // compare each result transfer, then record the answer for each input transfer
  always @(posedge clk_i) begin
    bit want;
    bit tied;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_before_q.size() == 0) begin
          $error("first_before: no pair outstanding, got %0b", m_tdata_i[0]);
          mismatch_cnt++;
        end else begin
          want = expected_before_q.pop_front();
          result_cnt++;
          if (m_tdata_i[0] !== want) begin
            $error("first_before mismatch: expected %0b, got %0b", want, m_tdata_i[0]);
            mismatch_cnt++;
          end
          if (m_tdata_i[7:1] !== 7'd0) begin
            $error("pad mismatch: expected %0h, got %0h", 7'd0, m_tdata_i[7:1]);
            mismatch_cnt++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        want = predict_first_before(seg_pair_t'(s_tdata_i[$bits(seg_pair_t)-1:0]), tied);
        expected_before_q.push_back(want);
        if (tied) tie_cnt++;
      end
      pending_cnt <= expected_before_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// stimulus, clocking and verdict for the sweep segment order comparator
`timescale 1ns / 100ps

module tb_top;
  import ssoc_pkg::*;

  localparam int unsigned CW          = COORD_WIDTH_DEF;
  localparam int unsigned IW          = IDENT_WIDTH_DEF;
  localparam int unsigned IN_W        = ((8 * CW + 2 * IW + 7) / 8) * 8;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 120;

  logic            clk_i;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;

  int mismatches;
  int pending;
  int results;
  int tie_breaks;

  // stimulus mode flags for the sender and the result sink
  bit sender_calm  = 1'b0;
  bit sink_calm    = 1'b0;
  bit hold_request = 1'b0;

  sweep_segment_order_compare_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ssoc_order_checker #(.CW(CW), .IW(IW), .IN_W(IN_W)) order_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .tie_breaks_o (tie_breaks)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result sink: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= sink_calm || ($urandom_range(99) >= 34);
      end
    end
  end

  function automatic logic [IN_W-1:0] pack_pair(input int s1x, s1y, e1x, e1y, id1,
                                                input int s2x, s2y, e2x, e2y, id2);
    return {IW'(id2), CW'(e2y), CW'(e2x), CW'(s2y), CW'(s2x),
            IW'(id1), CW'(e1y), CW'(e1x), CW'(s1y), CW'(s1x)};
  endfunction

  // offer one pair, with random idle cycles ahead of it, and wait for the transfer
  task automatic offer_pair(input logic [IN_W-1:0] data);
    while (!sender_calm && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering until every outstanding answer has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // random pair, biased toward shared starts, collinear lines and ties
  task automatic offer_random_pair();
    int c[8];
    int id1, id2, mode, bx, by, dx, dy, k;
    mode = $urandom_range(99);
    for (int i = 0; i < 8; i++) c[i] = int'($urandom_range(65535)) - 32768;
    id1 = $urandom_range(65535);
    id2 = $urandom_range(65535);
    if (mode < 25) begin
      // tiny grid: many equal starts and zero areas
      for (int i = 0; i < 8; i++) c[i] = int'($urandom_range(8)) - 4;
    end else if (mode < 45) begin
      // all four points on one line
      bx = int'($urandom_range(2000)) - 1000;
      by = int'($urandom_range(2000)) - 1000;
      dx = int'($urandom_range(80)) - 40;
      dy = int'($urandom_range(80)) - 40;
      for (int j = 0; j < 4; j++) begin
        k = int'($urandom_range(8)) - 4;
        c[2*j]   = bx + k * dx;
        c[2*j+1] = by + k * dy;
      end
    end else if (mode < 58) begin
      // shared start point
      c[4] = c[0];
      c[5] = c[1];
    end else if (mode < 66) begin
      // point-like segments
      k = $urandom_range(2);
      if (k != 1) begin
        c[2] = c[0];
        c[3] = c[1];
      end
      if (k != 0) begin
        c[6] = c[4];
        c[7] = c[5];
      end
    end else if (mode < 72) begin
      // same start x, order decided by y
      c[4] = c[0];
    end else if (mode < 78) begin
      id2 = id1;
    end
    if ($urandom_range(9) == 0) id2 = id1 ^ 1;
    offer_pair(pack_pair(c[0], c[1], c[2], c[3], id1, c[4], c[5], c[6], c[7], id2));
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // equal identities answer false whatever the geometry
    offer_pair(pack_pair(0, 0, 10, 10, 5, 3, -2, 8, 8, 5));
    offer_pair(pack_pair(-32768, -32768, 32767, 32767, 65535,
                         -32768, -32768, 32767, 32767, 65535));
    // shared start: far end on either side, then collinear with both identity orders
    offer_pair(pack_pair(0, 0, 10, 0, 1, 0, 0, 10, 5, 2));
    offer_pair(pack_pair(0, 0, 10, 0, 1, 0, 0, 10, -5, 2));
    offer_pair(pack_pair(0, 0, 10, 0, 1, 0, 0, 20, 0, 2));
    offer_pair(pack_pair(0, 0, 10, 0, 2, 0, 0, 20, 0, 1));
    // segment 1 starts first
    offer_pair(pack_pair(-5, 0, 5, 0, 3, 0, 4, 6, 4, 4));
    offer_pair(pack_pair(-5, 0, 5, 0, 3, 0, -4, 6, -4, 4));
    offer_pair(pack_pair(-5, 0, 5, 0, 3, 0, 0, 6, 4, 4));
    offer_pair(pack_pair(-5, 0, 5, 0, 3, 0, 0, 6, -4, 4));
    offer_pair(pack_pair(-5, 0, 5, 0, 3, 0, 0, 9, 0, 4));
    offer_pair(pack_pair(2, -3, 8, 1, 7, 2, 5, 9, 5, 6));
    // segment 2 starts first
    offer_pair(pack_pair(0, 4, 6, 4, 4, -5, 0, 5, 0, 3));
    offer_pair(pack_pair(0, -4, 6, -4, 4, -5, 0, 5, 0, 3));
    offer_pair(pack_pair(0, 0, 6, 4, 4, -5, 0, 5, 0, 3));
    offer_pair(pack_pair(0, 0, 6, -4, 4, -5, 0, 5, 0, 3));
    offer_pair(pack_pair(0, 0, 9, 0, 4, -5, 0, 5, 0, 3));
    offer_pair(pack_pair(2, 5, 9, 5, 6, 2, -3, 8, 1, 7));
    // point-like segments
    offer_pair(pack_pair(1, 1, 1, 1, 10, 0, 0, 4, 4, 11));
    offer_pair(pack_pair(3, 3, 3, 3, 12, 3, 3, 3, 3, 11));
    // coordinate and identity extremes
    offer_pair(pack_pair(-32768, -32768, 32767, 32767, 0, 32767, -32768, -32768, 32767, 65535));
    offer_pair(pack_pair(32767, 32767, -32768, -32768, 65535, -32768, 32767, 32767, -32768, 0));
    offer_pair(pack_pair(32767, 32767, 32767, -32768, 0, 32767, 32767, -32768, 32767, 1));
    offer_pair(pack_pair(-32768, 0, 32767, 0, 65535, -32768, 0, 0, 0, 0));
    drain_results();

    repeat (250) offer_random_pair();

    // long receiver hold-off while the sender keeps offering
    hold_request = 1'b1;
    sender_calm  = 1'b1;
    repeat (40) offer_random_pair();
    sender_calm = 1'b0;
    drain_results();

    // stretch with no idling on either side
    sender_calm = 1'b1;
    sink_calm   = 1'b1;
    repeat (120) offer_random_pair();
    sender_calm = 1'b0;
    sink_calm   = 1'b0;

    repeat (290) offer_random_pair();
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d segment pairs, %0d of them settled by a collinear or identity tie",
             results, tie_breaks);
    $display("stimulus included extremes, shared starts, point segments and a long output stall");
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
